// ===== rtl/core/json_string_unescaper_top_macros.svh =====
// assertion macros shared by the json string unescaper rtl
// no dependencies; pulled in by files that carry concurrent assertions
`ifndef JSON_STRING_UNESCAPER_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/jsu_pkg.sv =====
// types and constants for the json string unescaper
// no dependencies; used by json_string_unescaper_top
package jsu_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ErrW   = 4;
    localparam int unsigned BurstN = 4;
    localparam int unsigned CntW   = 3;
    localparam int unsigned UserW  = 2 + ErrW;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_BODY    = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX1    = 3'd3,
        MODE_NEED_BS = 3'd4,
        MODE_NEED_U  = 3'd5,
        MODE_HEX2    = 3'd6
    } parse_mode_t;

    typedef logic [ErrW-1:0] err_code_t;

    localparam err_code_t ERR_OK            = 4'd0;
    localparam err_code_t ERR_NO_OPEN_QUOTE = 4'd1;
    localparam err_code_t ERR_CONTROL       = 4'd2;
    localparam err_code_t ERR_TRUNC_ESC     = 4'd3;
    localparam err_code_t ERR_BAD_ESC       = 4'd4;
    localparam err_code_t ERR_TRUNC_UNI     = 4'd5;
    localparam err_code_t ERR_BAD_HEX       = 4'd6;
    localparam err_code_t ERR_HIGH_ALONE    = 4'd7;
    localparam err_code_t ERR_BAD_LOW       = 4'd8;
    localparam err_code_t ERR_UNPAIRED_LOW  = 4'd9;
    localparam err_code_t ERR_UNTERMINATED  = 4'd10;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

endpackage

// ===== rtl/core/json_string_unescaper_top.sv =====
// json string literal unescaper with utf-8 output, one byte in per transaction
// depends on jsu_pkg and json_string_unescaper_top_macros.svh
// a result is registered and appears on the m_ side in the cycle after its input transaction
// throughput: one input byte per cycle while each byte yields at most one result and m_tready is high;
//   a \u escape that expands to k utf-8 bytes holds s_tready low while the result register drains,
//   one byte per output transaction, until its last byte is leaving
// reset: aresetn synchronous active low; parser waits for an opening quote, results empty
`include "json_string_unescaper_top_macros.svh"

module json_string_unescaper_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input byte stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [jsu_pkg::ByteW-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                       s_tuser,   // [0] input_ends
    // decoded result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [jsu_pkg::ByteW-1:0]  m_tdata,   // [7:0] out_byte
    output logic [jsu_pkg::UserW-1:0]  m_tuser,   // [0] out_valid, [1] string_done,
                                                  // [5:2] error_code
    output logic                       m_tlast    // run_last
);

    // ------------------------------------------------------------------
    // parser state
    // ------------------------------------------------------------------
    jsu_pkg::parse_mode_t mode_reg, mode_next;
    logic [1:0]           hcnt_reg, hcnt_next;    // hex digits taken so far
    logic [15:0]          hacc_reg, hacc_next;    // value of those digits
    logic [9:0]           pend_reg, pend_next;    // high surrogate minus 0xd800

    // result register: up to four beats, first beat in the low byte
    logic [jsu_pkg::BurstN*jsu_pkg::ByteW-1:0] bytes_reg, bytes_next;
    logic [jsu_pkg::CntW-1:0]                  cnt_reg, cnt_next;
    logic                                      obyte_reg, obyte_next;
    logic                                      done_reg, done_next;
    jsu_pkg::err_code_t                        err_reg, err_next;

    // result of the byte being accepted
    logic [jsu_pkg::BurstN*jsu_pkg::ByteW-1:0] res_bytes;
    logic [jsu_pkg::CntW-1:0]                  res_n;
    logic                                      res_obyte;
    logic                                      res_done;
    jsu_pkg::err_code_t                        res_err;

    logic s_fire;
    logic m_fire;

    // ------------------------------------------------------------------
    // handshake: a new byte may enter while the last pending beat leaves
    // ------------------------------------------------------------------
    assign m_tvalid = (cnt_reg != '0);
    assign s_tready = (cnt_reg == '0)
                   || ((cnt_reg == jsu_pkg::CntW'(1)) && m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    assign m_tdata  = bytes_reg[jsu_pkg::ByteW-1:0];
    assign m_tuser  = {err_reg, done_reg, obyte_reg};
    assign m_tlast  = (cnt_reg == jsu_pkg::CntW'(1));

    // ------------------------------------------------------------------
    // byte classification shared by state and result logic
    // ------------------------------------------------------------------
    logic       is_dec, is_lc_hex, is_uc_hex, is_hex;
    logic [3:0] hex_val;
    logic [15:0] hex_word;       // accumulator with this digit appended
    logic        hex_last;       // this digit completes the escape
    logic        word_high;
    logic        word_low;

    assign is_dec    = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
    assign is_lc_hex = (s_tdata >= 8'h61) && (s_tdata <= 8'h66);
    assign is_uc_hex = (s_tdata >= 8'h41) && (s_tdata <= 8'h46);
    assign is_hex    = is_dec || is_lc_hex || is_uc_hex;
    // letters a-f and A-F both carry 1..6 in the low nibble
    assign hex_val   = is_dec ? s_tdata[3:0] : (s_tdata[3:0] + 4'd9);
    assign hex_word  = {hacc_reg[11:0], hex_val};
    assign hex_last  = (hcnt_reg == 2'd3);
    assign word_high = (hex_word >= jsu_pkg::HIGH_SURR_LO)
                    && (hex_word <= jsu_pkg::HIGH_SURR_HI);
    assign word_low  = (hex_word >= jsu_pkg::LOW_SURR_LO)
                    && (hex_word <= jsu_pkg::LOW_SURR_HI);

    // code point of a finished escape: plain bmp value or a surrogate pair
    logic [20:0] cp;
    assign cp = (mode_reg == jsu_pkg::MODE_HEX2)
              ? ({1'b0, pend_reg, hex_word[9:0]} + jsu_pkg::SUPP_BASE)
              : {5'd0, hex_word};

    // utf-8 encoding of cp
    logic [jsu_pkg::BurstN*jsu_pkg::ByteW-1:0] utf_bytes;
    logic [jsu_pkg::CntW-1:0]                  utf_n;

    always_comb begin
        if (cp < 21'h80) begin
            utf_n     = jsu_pkg::CntW'(1);
            utf_bytes = {24'd0, cp[7:0]};
        end else if (cp < 21'h800) begin
            utf_n     = jsu_pkg::CntW'(2);
            utf_bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
        end else if (cp < 21'h10000) begin
            utf_n     = jsu_pkg::CntW'(3);
            utf_bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
        end else begin
            utf_n     = jsu_pkg::CntW'(4);
            utf_bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                         5'b11110, cp[20:18]};
        end
    end

    // ------------------------------------------------------------------
    // next parser state
    // ------------------------------------------------------------------
    always_comb begin
        mode_next = mode_reg;
        hcnt_next = hcnt_reg;
        hacc_next = hacc_reg;
        pend_next = pend_reg;
        if (s_tuser) begin
            // end of source: any open string is an error, always back to waiting
            mode_next = jsu_pkg::MODE_IDLE;
            if (mode_reg != jsu_pkg::MODE_IDLE) begin
                hcnt_next = 2'd0;
                hacc_next = 16'd0;
            end
        end else begin
            unique case (mode_reg)
                jsu_pkg::MODE_BODY: begin
                    if (s_tdata == jsu_pkg::CH_QUOTE) begin
                        mode_next = jsu_pkg::MODE_IDLE;
                    end else if (s_tdata < jsu_pkg::CH_SPACE) begin
                        mode_next = jsu_pkg::MODE_IDLE;
                        hcnt_next = 2'd0;
                        hacc_next = 16'd0;
                    end else if (s_tdata == jsu_pkg::CH_BACKSLASH) begin
                        mode_next = jsu_pkg::MODE_ESC;
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    case (s_tdata)
                        jsu_pkg::CH_U: begin
                            mode_next = jsu_pkg::MODE_HEX1;
                            hcnt_next = 2'd0;
                            hacc_next = 16'd0;
                        end
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH,
                        jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                        jsu_pkg::CH_R, jsu_pkg::CH_T: begin
                            mode_next = jsu_pkg::MODE_BODY;
                        end
                        default: begin
                            mode_next = jsu_pkg::MODE_IDLE;
                            hcnt_next = 2'd0;
                            hacc_next = 16'd0;
                        end
                    endcase
                end
                jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                    if (!is_hex) begin
                        mode_next = jsu_pkg::MODE_IDLE;
                        hcnt_next = 2'd0;
                        hacc_next = 16'd0;
                    end else if (!hex_last) begin
                        hacc_next = hex_word;
                        hcnt_next = hcnt_reg + 2'd1;
                    end else begin
                        hcnt_next = 2'd0;
                        hacc_next = 16'd0;
                        if (mode_reg == jsu_pkg::MODE_HEX1) begin
                            if (word_high) begin
                                pend_next = hex_word[9:0];
                                mode_next = jsu_pkg::MODE_NEED_BS;
                            end else if (word_low) begin
                                mode_next = jsu_pkg::MODE_IDLE;
                            end else begin
                                mode_next = jsu_pkg::MODE_BODY;
                            end
                        end else begin
                            mode_next = word_low ? jsu_pkg::MODE_BODY
                                                 : jsu_pkg::MODE_IDLE;
                        end
                    end
                end
                jsu_pkg::MODE_NEED_BS: begin
                    if (s_tdata == jsu_pkg::CH_BACKSLASH) begin
                        mode_next = jsu_pkg::MODE_NEED_U;
                    end else begin
                        mode_next = jsu_pkg::MODE_IDLE;
                        hcnt_next = 2'd0;
                        hacc_next = 16'd0;
                    end
                end
                jsu_pkg::MODE_NEED_U: begin
                    hcnt_next = 2'd0;
                    hacc_next = 16'd0;
                    mode_next = (s_tdata == jsu_pkg::CH_U) ? jsu_pkg::MODE_HEX2
                                                           : jsu_pkg::MODE_IDLE;
                end
                default: begin
                    // waiting for an opening quote (unused code behaves the same)
                    if (s_tdata == jsu_pkg::CH_QUOTE) begin
                        mode_next = jsu_pkg::MODE_BODY;
                    end else begin
                        mode_next = jsu_pkg::MODE_IDLE;
                        hcnt_next = 2'd0;
                        hacc_next = 16'd0;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // results caused by the byte being accepted
    // ------------------------------------------------------------------
    always_comb begin
        res_bytes = '0;
        res_n     = '0;
        res_obyte = 1'b0;
        res_done  = 1'b0;
        res_err   = jsu_pkg::ERR_OK;
        if (s_tuser) begin
            unique case (mode_reg)
                jsu_pkg::MODE_BODY:                        res_err = jsu_pkg::ERR_UNTERMINATED;
                jsu_pkg::MODE_ESC:                         res_err = jsu_pkg::ERR_TRUNC_ESC;
                jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2:    res_err = jsu_pkg::ERR_TRUNC_UNI;
                jsu_pkg::MODE_NEED_BS, jsu_pkg::MODE_NEED_U: res_err = jsu_pkg::ERR_HIGH_ALONE;
                default:                                   res_err = jsu_pkg::ERR_OK;
            endcase
            res_n = (res_err != jsu_pkg::ERR_OK) ? jsu_pkg::CntW'(1) : '0;
        end else begin
            unique case (mode_reg)
                jsu_pkg::MODE_BODY: begin
                    res_n = jsu_pkg::CntW'(1);
                    if (s_tdata == jsu_pkg::CH_QUOTE) begin
                        res_done = 1'b1;
                    end else if (s_tdata < jsu_pkg::CH_SPACE) begin
                        res_err = jsu_pkg::ERR_CONTROL;
                    end else if (s_tdata == jsu_pkg::CH_BACKSLASH) begin
                        res_n = '0;
                    end else begin
                        res_obyte = 1'b1;
                        res_bytes = {24'd0, s_tdata};
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    res_n     = jsu_pkg::CntW'(1);
                    res_obyte = 1'b1;
                    case (s_tdata)
                        jsu_pkg::CH_U: begin
                            res_n     = '0;
                            res_obyte = 1'b0;
                        end
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH,
                        jsu_pkg::CH_SLASH: res_bytes = {24'd0, s_tdata};
                        jsu_pkg::CH_B:     res_bytes = {24'd0, 8'h08};
                        jsu_pkg::CH_F:     res_bytes = {24'd0, 8'h0C};
                        jsu_pkg::CH_N:     res_bytes = {24'd0, 8'h0A};
                        jsu_pkg::CH_R:     res_bytes = {24'd0, 8'h0D};
                        jsu_pkg::CH_T:     res_bytes = {24'd0, 8'h09};
                        default: begin
                            res_obyte = 1'b0;
                            res_err   = jsu_pkg::ERR_BAD_ESC;
                        end
                    endcase
                end
                jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                    if (!is_hex) begin
                        res_n   = jsu_pkg::CntW'(1);
                        res_err = jsu_pkg::ERR_BAD_HEX;
                    end else if (hex_last) begin
                        if ((mode_reg == jsu_pkg::MODE_HEX1) && word_high) begin
                            res_n = '0;
                        end else if ((mode_reg == jsu_pkg::MODE_HEX1) && word_low) begin
                            res_n   = jsu_pkg::CntW'(1);
                            res_err = jsu_pkg::ERR_UNPAIRED_LOW;
                        end else if ((mode_reg == jsu_pkg::MODE_HEX2) && !word_low) begin
                            res_n   = jsu_pkg::CntW'(1);
                            res_err = jsu_pkg::ERR_BAD_LOW;
                        end else begin
                            res_n     = utf_n;
                            res_obyte = 1'b1;
                            res_bytes = utf_bytes;
                        end
                    end
                end
                jsu_pkg::MODE_NEED_BS: begin
                    if (s_tdata != jsu_pkg::CH_BACKSLASH) begin
                        res_n   = jsu_pkg::CntW'(1);
                        res_err = jsu_pkg::ERR_HIGH_ALONE;
                    end
                end
                jsu_pkg::MODE_NEED_U: begin
                    if (s_tdata != jsu_pkg::CH_U) begin
                        res_n   = jsu_pkg::CntW'(1);
                        res_err = jsu_pkg::ERR_HIGH_ALONE;
                    end
                end
                default: begin
                    if (s_tdata != jsu_pkg::CH_QUOTE) begin
                        res_n   = jsu_pkg::CntW'(1);
                        res_err = jsu_pkg::ERR_NO_OPEN_QUOTE;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result register: load on accept, shift one byte per output transaction
    // ------------------------------------------------------------------
    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        obyte_next = obyte_reg;
        done_next  = done_reg;
        err_next   = err_reg;
        if (m_fire) begin
            bytes_next = {8'd0, bytes_reg[jsu_pkg::BurstN*jsu_pkg::ByteW-1:jsu_pkg::ByteW]};
            cnt_next   = cnt_reg - jsu_pkg::CntW'(1);
        end
        // s_fire implies the register is empty or emptying now
        if (s_fire) begin
            bytes_next = res_bytes;
            cnt_next   = res_n;
            obyte_next = res_obyte;
            done_next  = res_done;
            err_next   = res_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= jsu_pkg::MODE_IDLE;
            hcnt_reg <= 2'd0;
            hacc_reg <= 16'd0;
            pend_reg <= 10'd0;
            cnt_reg  <= '0;
        end else begin
            if (s_fire) begin
                mode_reg <= mode_next;
                hcnt_reg <= hcnt_next;
                hacc_reg <= hacc_next;
                pend_reg <= pend_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        obyte_reg <= obyte_next;
        done_reg  <= done_next;
        err_reg   <= err_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a multi-beat run only ever carries utf-8 bytes
    `JSU_ASSERT_NOW(a_burst_is_data, aclk, aresetn, (cnt_reg > jsu_pkg::CntW'(1)), (obyte_reg && !done_reg && (err_reg == jsu_pkg::ERR_OK)), "multi-beat run carries a status result")
    // an error result is a single beat without data
    `JSU_ASSERT_NOW(a_err_single, aclk, aresetn, (m_tvalid && (err_reg != jsu_pkg::ERR_OK)), (m_tlast && !obyte_reg && (m_tdata == 8'd0)), "error result is not a lone empty beat")
    // a non-final beat taken leaves more beats pending
    `JSU_ASSERT_NEXT(a_run_continues, aclk, aresetn, (m_fire && !m_tlast), m_tvalid, "run ended before its last beat")
    // after an error is produced the parser waits for an opening quote
    `JSU_ASSERT_NEXT(a_err_to_idle, aclk, aresetn, (s_fire && (res_err != jsu_pkg::ERR_OK)), (mode_reg == jsu_pkg::MODE_IDLE), "parser left open after an error")

endmodule
